// ===== hdl/vpd_pkg.sv =====
package vpd_pkg;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        non_reference;
    logic        start_of_partition;
    logic [2:0]  partition_index;
    logic [1:0]  picture_id_kind;
    logic [14:0] picture_id;
    logic [1:0]  extras_present;
    logic [7:0]  tl0_index;
    logic [1:0]  temporal_layer;
    logic        layer_sync;
    logic [4:0]  key_index;
    logic        is_key_frame;
  } out_item_t;

  // Request moved from the input register into the parser.
  typedef struct packed {
    logic     step;
    in_item_t item;
  } step_req_t;

endpackage

// ===== hdl/vp8_payload_descriptor_parser_core.sv =====
// VP8 RTP payload descriptor parser. Payload bytes enter on the input channel,
// with last_byte set on the final byte of each payload; exactly one result
// leaves per payload, on its last byte. Each accepted byte lands in an input
// register and, unless it is a held last byte, is folded into the phase state
// in the following cycle, so the block sustains one byte per clock while no
// last byte is held. The result is formed from a payload's last byte and is
// loaded into the output register once that is free; it sits there until
// taken. A last byte waits in the input register while the previous result
// is still pending downstream, and the bytes behind it wait with it; all other
// bytes keep flowing. Status reports ok, a payload without the extension bit,
// or a descriptor cut short; on a non-ok status every other field reads zero.
module vp8_payload_descriptor_parser_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vpd_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output vpd_pkg::out_item_t  out_item
);

  vpd_pkg::step_req_t  req;
  vpd_pkg::out_item_t  result;
  logic                result_load;
  logic                result_free;

  vpd_input_reg u_input_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .result_free (result_free),
    .req         (req)
  );

  vpd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .result_load (result_load),
    .result      (result)
  );

  vpd_result_reg u_result_reg (
    .clk         (clk),
    .rst         (rst),
    .result_load (result_load),
    .result      (result),
    .result_free (result_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule

// ===== hdl/vpd_input_reg.sv =====
module vpd_input_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vpd_pkg::in_item_t   in_item,
  input  logic                result_free,
  output vpd_pkg::step_req_t  req
);

  logic              held_valid;
  vpd_pkg::in_item_t held_item;
  logic              advance;

  // A last byte waits here until the result register can take its result.
  assign advance  = held_valid && (!held_item.last_byte || result_free);
  assign in_ready = !held_valid || advance;

  assign req.step = advance;
  assign req.item = held_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

// ===== hdl/vpd_parser.sv =====
module vpd_parser (
  input  logic                clk,
  input  logic                rst,
  input  vpd_pkg::step_req_t  req,
  output logic                result_load,
  output vpd_pkg::out_item_t  result
);

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_EXT    = 3'd1,
    PH_PID1   = 3'd2,
    PH_PID2   = 3'd3,
    PH_TL0    = 3'd4,
    PH_LAYER  = 3'd5,
    PH_KEYCHK = 3'd6,
    PH_SKIP   = 3'd7
  } phase_t;

  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_NOT_EXTENDED = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED    = 2'd2;

  localparam logic [1:0] KIND_ABSENT = 2'd0;
  localparam logic [1:0] KIND_SHORT  = 2'd1;
  localparam logic [1:0] KIND_LONG   = 2'd2;

  phase_t      phase, phase_next;
  logic [3:0]  ext_flags, ext_flags_next;
  logic [4:0]  hdr, hdr_next;
  logic [14:0] pic_id, pic_id_next;
  logic [1:0]  pic_kind, pic_kind_next;
  logic [7:0]  tl0, tl0_next;
  logic [7:0]  layer, layer_next;
  logic [1:0]  extras, extras_next;
  logic        key, key_next;
  logic [1:0]  status, status_next;

  logic [7:0]  b;
  logic [1:0]  st;

  // Next phase once 'done' is complete, skipping parts that are absent.
  function automatic phase_t phase_after(input phase_t done, input logic [3:0] flags);
    phase_t p;
    if (done < PH_PID1 && flags[3]) begin
      p = PH_PID1;
    end else if (done < PH_TL0 && flags[2]) begin
      p = PH_TL0;
    end else if (done < PH_LAYER && (flags[1] || flags[0])) begin
      p = PH_LAYER;
    end else begin
      p = PH_KEYCHK;
    end
    return p;
  endfunction

  assign b = req.item.payload_byte;

  always_comb begin
    phase_next     = phase;
    ext_flags_next = ext_flags;
    hdr_next       = hdr;
    pic_id_next    = pic_id;
    pic_kind_next  = pic_kind;
    tl0_next       = tl0;
    layer_next     = layer;
    extras_next    = extras;
    key_next       = key;
    status_next    = status;
    case (phase)
      PH_FIRST: begin
        ext_flags_next = 4'd0;
        pic_id_next    = 15'd0;
        pic_kind_next  = KIND_ABSENT;
        tl0_next       = 8'd0;
        layer_next     = 8'd0;
        extras_next    = 2'd0;
        key_next       = 1'b0;
        hdr_next       = {b[5], b[4], b[2:0]};
        if (b[7]) begin
          status_next = STATUS_OK;
          phase_next  = PH_EXT;
        end else begin
          status_next = STATUS_NOT_EXTENDED;
          phase_next  = PH_SKIP;
        end
      end
      PH_EXT: begin
        ext_flags_next = b[7:4];
        extras_next    = {b[5] || b[4], b[6]};
        phase_next     = phase_after(PH_EXT, b[7:4]);
      end
      PH_PID1: begin
        if (b[7]) begin
          pic_kind_next = KIND_LONG;
          pic_id_next   = {b[6:0], 8'd0};
          phase_next    = PH_PID2;
        end else begin
          pic_kind_next = KIND_SHORT;
          pic_id_next   = {8'd0, b[6:0]};
          phase_next    = phase_after(PH_PID2, ext_flags);
        end
      end
      PH_PID2: begin
        pic_id_next = {pic_id[14:8], pic_id[7:0] | b};
        phase_next  = phase_after(PH_PID2, ext_flags);
      end
      PH_TL0: begin
        tl0_next   = b;
        phase_next = phase_after(PH_TL0, ext_flags);
      end
      PH_LAYER: begin
        layer_next = b;
        phase_next = PH_KEYCHK;
      end
      PH_KEYCHK: begin
        if (hdr[3] && hdr[2:0] == 3'd0 && !b[0]) begin
          key_next = 1'b1;
        end
        phase_next = PH_SKIP;
      end
      default: begin
        phase_next = PH_SKIP;
      end
    endcase
  end

  always_comb begin
    if (status_next != STATUS_OK) begin
      st = status_next;
    end else if (phase_next >= PH_EXT && phase_next <= PH_LAYER) begin
      st = STATUS_TRUNCATED;
    end else begin
      st = STATUS_OK;
    end
    result = '0;
    result.status = st;
    if (st == STATUS_OK) begin
      result.non_reference      = hdr_next[4];
      result.start_of_partition = hdr_next[3];
      result.partition_index    = hdr_next[2:0];
      result.picture_id_kind    = pic_kind_next;
      result.picture_id         = pic_id_next;
      result.extras_present     = extras_next;
      result.tl0_index          = tl0_next;
      if (extras_next[1]) begin
        result.temporal_layer = layer_next[7:6];
        result.layer_sync     = layer_next[5];
        result.key_index      = layer_next[4:0];
      end
      result.is_key_frame = key_next;
    end
  end

  assign result_load = req.step && req.item.last_byte;

  always_ff @(posedge clk) begin
    if (rst || result_load) begin
      phase     <= PH_FIRST;
      ext_flags <= 4'd0;
      hdr       <= 5'd0;
      pic_id    <= 15'd0;
      pic_kind  <= KIND_ABSENT;
      tl0       <= 8'd0;
      layer     <= 8'd0;
      extras    <= 2'd0;
      key       <= 1'b0;
      status    <= STATUS_OK;
    end else if (req.step) begin
      phase     <= phase_next;
      ext_flags <= ext_flags_next;
      hdr       <= hdr_next;
      pic_id    <= pic_id_next;
      pic_kind  <= pic_kind_next;
      tl0       <= tl0_next;
      layer     <= layer_next;
      extras    <= extras_next;
      key       <= key_next;
      status    <= status_next;
    end
  end

endmodule

// ===== hdl/vpd_result_reg.sv =====
module vpd_result_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                result_load,
  input  vpd_pkg::out_item_t  result,
  output logic                result_free,
  output logic                out_valid,
  input  logic                out_ready,
  output vpd_pkg::out_item_t  out_item
);

  assign result_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_free) begin
      out_valid <= result_load;
    end
    if (result_load) begin
      out_item <= result;
    end
  end

endmodule
